// ----- design/kbpf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kbpf_pkg
// Shared types and constants for the kinematic blend position filter.
// ----------------------------------------------------------------------------
package kbpf_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int STATE_COUNT = 6;
    localparam int SIDX_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 31;
    localparam int SUM_W       = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd3;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_POS  = 2'd1;
    localparam logic [1:0] MODE_ALL  = 2'd2;
    localparam logic [1:0] MODE_VEL  = 2'd3;

    localparam logic OP_READING  = 1'b0;
    localparam logic OP_ESTIMATE = 1'b1;

    // one queued command between front and back
    typedef struct packed {
        logic               opcode;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic [30:0]        duration;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,     // predictions, one multiply a cycle
        ST_BLEND,    // blend each element
        ST_DIV,      // averages through the serial divider
        ST_VELPOS,   // velocity mode position products
        ST_COMMIT,
        ST_OUT
    } t_state;

    // saturate a 66-bit signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // round a product /65536 to nearest, ties up (arithmetic shift floors)
    function automatic logic signed [65:0] rnd16(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd32768;
        return t >>> 16;
    endfunction

endpackage
`default_nettype wire

// ----- design/kbpf_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kbpf_front
// Input stage and two-entry command queue toward the back end.
// ----------------------------------------------------------------------------
module kbpf_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire kbpf_pkg::t_cmd i_cmd,
    output logic                o_valid,
    input  wire logic           i_pop,
    output kbpf_pkg::t_cmd      o_cmd
);
    kbpf_pkg::t_cmd r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ----- design/kbpf_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kbpf_div
// Radix-2 signed divider: 48-bit sum by unsigned count, truncating.
// ----------------------------------------------------------------------------
module kbpf_div (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic signed [kbpf_pkg::SUM_W-1:0]     i_num,
    input  wire logic [kbpf_pkg::COUNT_WIDTH-1:0]      i_den,
    output logic                                       o_done,
    output logic signed [31:0]                         o_quo
);
    localparam int NW = kbpf_pkg::SUM_W;
    localparam int DW = kbpf_pkg::COUNT_WIDTH;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic          r_neg, r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW:0]   w_trial;
    logic [NW:0]   w_sq;

    assign w_trial = {r_rem[DW-1:0], r_q[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_neg  <= i_num[NW-1];
                r_q    <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                // one quotient bit per cycle
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= w_trial - {1'b0, r_den};
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign w_sq  = r_neg ? -{1'b0, r_q} : {1'b0, r_q};
    assign o_quo = kbpf_pkg::sat32(66'(signed'(w_sq)));
endmodule
`default_nettype wire

// ----- design/kbpf_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kbpf_back
// Sequencer for the filter update and window estimate; one shared multiplier serves the
// prediction and velocity-mode products, and the blend has its own gain multiply.
module kbpf_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [kbpf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [kbpf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic           i_cmd_valid,
    input  wire kbpf_pkg::t_cmd i_cmd,
    output logic                o_pop,
    output logic                o_res_valid,
    input  wire logic           i_res_ready,
    output logic signed [31:0]  o_pos_x,
    output logic signed [31:0]  o_pos_y,
    output logic                o_empty
);
    localparam int SC = kbpf_pkg::STATE_COUNT;
    localparam int SW = kbpf_pkg::SIDX_W;
    localparam int CN = kbpf_pkg::COUNT_WIDTH;

    logic [16:0] r_gain;
    logic [30:0] r_dt, r_hs;
    logic [1:0]  r_mode;

    logic signed [31:0] r_x   [SC];
    logic signed [31:0] r_z   [SC];
    logic signed [31:0] r_avg [SC];
    logic signed [kbpf_pkg::SUM_W-1:0] r_sum [SC];
    logic signed [31:0] r_ws  [2];
    logic [CN-1:0]      r_count;
    logic signed [49:0] r_pacc;  // position plus velocity term, unsaturated

    kbpf_pkg::t_state r_st, n_st;
    logic [SW-1:0]    r_i;
    logic             r_ph;      // second product for position elements
    kbpf_pkg::t_cmd   r_cmd;
    logic             r_dstart;

    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;
    logic signed [65:0] w_rp;
    logic               w_ddone;
    logic signed [31:0] w_quo;
    logic [16:0]        w_g;
    logic signed [32:0] w_diff;

    assign w_g    = (r_gain > 17'd65536) ? 17'd65536 : r_gain;
    assign w_diff = 33'(r_z[r_i]) - 33'(r_x[r_i]);

    // operand selection for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_st)
            kbpf_pkg::ST_PRED: begin
                if (r_i < SW'(2)) begin
                    w_ma = r_ph ? signed'({1'b0, r_hs}) : signed'({1'b0, r_dt});
                    w_mb = r_ph ? (r_i[0] ? r_cmd.accel_y : r_cmd.accel_x)
                                : r_x[r_i + SW'(2)];
                end else begin
                    w_ma = signed'({1'b0, r_dt});
                    w_mb = r_i[0] ? r_cmd.accel_y : r_cmd.accel_x;
                end
            end
            kbpf_pkg::ST_VELPOS: begin
                w_ma = r_avg[r_i + SW'(2)];
                w_mb = signed'({1'b0, r_cmd.duration});
            end
            default: begin
            end
        endcase
    end

    assign w_prod = 64'(w_ma) * 64'(w_mb);
    assign w_rp   = kbpf_pkg::rnd16(66'(w_prod));

    kbpf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_sum[r_i]),
        .i_den   (r_count),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    always_comb begin
        n_st  = r_st;
        o_pop = 1'b0;
        unique case (r_st)
            kbpf_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_pop = 1'b1;
                    if (i_cmd.opcode == kbpf_pkg::OP_READING) n_st = kbpf_pkg::ST_PRED;
                    else if (r_count == '0)                   n_st = kbpf_pkg::ST_COMMIT;
                    else                                      n_st = kbpf_pkg::ST_DIV;
                end
            end
            kbpf_pkg::ST_PRED: begin
                if (r_i == SW'(3)) n_st = kbpf_pkg::ST_BLEND;
            end
            kbpf_pkg::ST_BLEND: begin
                if (r_i == SW'(SC - 1)) n_st = kbpf_pkg::ST_IDLE;
            end
            kbpf_pkg::ST_DIV: begin
                if (w_ddone && r_i == SW'(SC - 1)) begin
                    n_st = (r_mode == kbpf_pkg::MODE_VEL) ? kbpf_pkg::ST_VELPOS
                                                          : kbpf_pkg::ST_COMMIT;
                end
            end
            kbpf_pkg::ST_VELPOS: begin
                if (r_i == SW'(1)) n_st = kbpf_pkg::ST_COMMIT;
            end
            kbpf_pkg::ST_COMMIT: n_st = kbpf_pkg::ST_OUT;
            kbpf_pkg::ST_OUT: begin
                if (i_res_ready) n_st = kbpf_pkg::ST_IDLE;
            end
            default: n_st = kbpf_pkg::ST_IDLE;
        endcase
    end

    assign o_res_valid = (r_st == kbpf_pkg::ST_OUT);
    assign o_pos_x     = r_ws[0];
    assign o_pos_y     = r_ws[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= kbpf_pkg::ST_IDLE;
            r_i      <= '0;
            r_ph     <= 1'b0;
            r_dstart <= 1'b0;
            r_gain   <= 17'd6554;
            r_dt     <= 31'd65536;
            r_hs     <= 31'd32768;
            r_mode   <= kbpf_pkg::MODE_NONE;
            r_count  <= '0;
            o_empty  <= 1'b0;
            for (int k = 0; k < SC; k++) begin
                r_x[k]   <= '0;
                r_sum[k] <= '0;
            end
            r_ws[0] <= '0;
            r_ws[1] <= '0;
        end else begin
            r_st     <= n_st;
            r_dstart <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    kbpf_pkg::CFG_GAIN: r_gain <= i_cfg_data[16:0];
                    kbpf_pkg::CFG_STEP: r_dt   <= i_cfg_data;
                    kbpf_pkg::CFG_HALF: r_hs   <= i_cfg_data;
                    kbpf_pkg::CFG_MODE: r_mode <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            unique case (r_st)
                kbpf_pkg::ST_IDLE: begin
                    r_i  <= '0;
                    r_ph <= 1'b0;
                    if (i_cmd_valid) begin
                        r_cmd <= i_cmd;
                        if (i_cmd.opcode == kbpf_pkg::OP_ESTIMATE && r_count != '0) begin
                            r_dstart <= 1'b1;
                        end
                    end
                end
                kbpf_pkg::ST_PRED: begin
                    // position takes two products, velocity one; saturate only at the end
                    if (r_i < SW'(2) && !r_ph) begin
                        r_pacc <= 50'(66'(r_x[r_i]) + w_rp);
                        r_ph   <= 1'b1;
                    end else begin
                        if (r_i < SW'(2))
                            r_z[r_i] <= kbpf_pkg::sat32(66'(r_pacc) + w_rp);
                        else
                            r_z[r_i] <= kbpf_pkg::sat32(66'(r_x[r_i]) + w_rp);
                        r_ph <= 1'b0;
                        r_i  <= (r_i == SW'(3)) ? '0 : r_i + SW'(1);
                    end
                    r_z[4] <= r_cmd.accel_x;
                    r_z[5] <= r_cmd.accel_y;
                end
                kbpf_pkg::ST_BLEND: begin : blend
                    logic signed [31:0] nx;
                    logic signed [65:0] bp;
                    bp = 66'(signed'({1'b0, w_g})) * 66'(w_diff);
                    nx = kbpf_pkg::sat32(66'(r_x[r_i]) + kbpf_pkg::rnd16(bp));
                    r_x[r_i] <= nx;
                    if (66'(r_sum[r_i]) + 66'(nx) > 66'sd140737488355327)
                        r_sum[r_i] <= 48'sh7fffffffffff;
                    else if (66'(r_sum[r_i]) + 66'(nx) < -66'sd140737488355328)
                        r_sum[r_i] <= 48'sh800000000000;
                    else
                        r_sum[r_i] <= r_sum[r_i] + 48'(nx);
                    if (r_i == SW'(SC - 1)) begin
                        r_i <= '0;
                        if (r_count != '1) r_count <= r_count + CN'(1);
                    end else begin
                        r_i <= r_i + SW'(1);
                    end
                end
                kbpf_pkg::ST_DIV: begin
                    if (w_ddone) begin
                        r_avg[r_i] <= w_quo;
                        if (r_i == SW'(SC - 1)) begin
                            r_i <= '0;
                        end else begin
                            r_i      <= r_i + SW'(1);
                            r_dstart <= 1'b1;
                        end
                    end
                end
                kbpf_pkg::ST_VELPOS: begin
                    r_z[r_i] <= kbpf_pkg::sat32(66'(r_ws[r_i[0]]) + w_rp);
                    r_i      <= r_i + SW'(1);
                end
                kbpf_pkg::ST_COMMIT: begin : commit
                    logic signed [31:0] px, py;
                    px = r_x[0];
                    py = r_x[1];
                    o_empty <= (r_count == '0);
                    if (r_count != '0) begin
                        case (r_mode)
                            kbpf_pkg::MODE_POS: begin
                                px = r_avg[0]; py = r_avg[1];
                            end
                            kbpf_pkg::MODE_ALL: begin
                                px = r_avg[0]; py = r_avg[1];
                                for (int k = 2; k < SC; k++) r_x[k] <= r_avg[k];
                            end
                            kbpf_pkg::MODE_VEL: begin
                                px = r_z[0]; py = r_z[1];
                                r_x[2] <= r_avg[2];
                                r_x[3] <= r_avg[3];
                            end
                            default: ;
                        endcase
                    end
                    r_x[0]  <= px;
                    r_x[1]  <= py;
                    r_ws[0] <= px;
                    r_ws[1] <= py;
                    r_count <= '0;
                    for (int k = 0; k < SC; k++) r_sum[k] <= '0;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- design/kinematic_blend_position_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kinematic_blend_position_filter
// Planar constant-acceleration filter with windowed averaging estimates.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload
//  s_axis    in   tdata {duration[30:0], accel_y, accel_x}, tuser opcode
//  m_axis    out  tdata {pos_y, pos_x}, tuser empty_window
//  cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data, write only
//
//  A reading is taken from the queue, then makes six multiply steps on
//  the shared 32x32 multiplier, then six blend steps. An estimate is
//  dequeued, runs the six averages through the one-bit-per-cycle divider
//  (start, 48 steps, capture), takes two products in velocity mode, then
//  commits and outputs. An empty window goes straight to commit and output.
//  A two-entry queue lets input keep arriving while the back end works.
//  Reset is synchronous, active low; the result holds until taken.
// ----------------------------------------------------------------------------
module kinematic_blend_position_filter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // accel_x, accel_y, window_duration, pad
    input  wire logic        s_axis_tuser,  // opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // position_x, position_y
    output logic             m_axis_tuser,  // empty_window
    input  wire logic        i_cfg_we,
    input  wire logic [kbpf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [kbpf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    kbpf_pkg::t_cmd w_in, w_q;
    logic           w_qv, w_pop;
    logic signed [31:0] w_px, w_py;

    assign w_in.opcode   = s_axis_tuser;
    assign w_in.accel_x  = s_axis_tdata[31:0];
    assign w_in.accel_y  = s_axis_tdata[63:32];
    assign w_in.duration = s_axis_tdata[94:64];

    kbpf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (w_in),
        .o_valid (w_qv),
        .i_pop   (w_pop),
        .o_cmd   (w_q)
    );

    kbpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_qv),
        .i_cmd       (w_q),
        .o_pop       (w_pop),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_pos_x     (w_px),
        .o_pos_y     (w_py),
        .o_empty     (m_axis_tuser)
    );

    assign m_axis_tdata = {w_py, w_px};

    // hold the result stable while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // no pop from an empty queue
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qv)
        else $error("pop from empty queue");
    // an empty window keeps the reported position at its previous value
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) && m_axis_tuser |-> $stable(m_axis_tdata))
        else $error("empty window moved position");
endmodule
`default_nettype wire
